FILE: sv/bmh_pkg.sv
package bmh_pkg;

    localparam int PRIO_W  = 32;
    localparam int ID_W    = 32;
    localparam int COUNT_W = 6;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic signed [ID_W-1:0]   id;
    } entry_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_LAST_LD,
        ST_DN_RD,
        ST_DN_CMP,
        ST_DONE
    } state_t;

endpackage

FILE: sv/bmh_store.sv
module bmh_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  bmh_pkg::entry_t wr_data,
    input  logic [AW-1:0]   rd_a_addr,
    input  logic [AW-1:0]   rd_b_addr,
    output bmh_pkg::entry_t rd_a_data,
    output bmh_pkg::entry_t rd_b_data
);
    import bmh_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_a_reg;
    entry_t rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

FILE: sv/binary_min_heap_priority_queue_unit.sv
// binary min-heap priority queue of (priority, id) entries, smaller priority first
// input channel s_*: s_operation 0 inserts (s_priority_req, s_patron_id), 1 removes the minimum
// result channel m_*: one result per request with status, the removed entry, the count
// and the root entry after the operation (zeros where not meaningful)
// the heap lives in a single ram with one write and two registered read ports
// an insert climbs from the end of the heap, L being the levels climbed,
// and is written without a parent read at the root (also into an empty queue);
// a remove moves the last entry to the root and sifts it down, L being the levels
// descended, until it ends on a leaf or no child is smaller; L <= log2(CAPACITY)
// a full insert, an empty remove or the remove of the only entry skips the heap walk
// each level takes a ram read state and then a compare/write state
// one request is worked on at a time; s_ready is high whenever the walker is idle,
// so the next request is taken while a finished result still waits on m_ready
// the next request is taken in the cycle after a result is loaded
// a stalled receiver holds the result in the output register; a further finished
// result waits in the walker until the output register frees up
// reset (aresetn low, synchronous) empties the queue and drops any pending result;
// ram contents are not cleared, only entries below the count are ever read
module binary_min_heap_priority_queue_unit #(
    parameter int CAPACITY = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_operation,
    input  logic signed [bmh_pkg::PRIO_W-1:0]     s_priority_req,
    input  logic signed [bmh_pkg::ID_W-1:0]       s_patron_id,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0]                            m_status,
    output logic signed [bmh_pkg::PRIO_W-1:0]     m_removed_priority,
    output logic signed [bmh_pkg::ID_W-1:0]       m_removed_id,
    output logic [bmh_pkg::COUNT_W-1:0]           m_entry_count_out,
    output logic                                  m_min_valid,
    output logic signed [bmh_pkg::PRIO_W-1:0]     m_min_priority,
    output logic signed [bmh_pkg::ID_W-1:0]       m_min_id
);
    import bmh_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   pos_reg, pos_next;
    entry_t          hold_reg, hold_next;
    entry_t          root_reg;
    status_t         status_reg, status_next;
    entry_t          removed_reg, removed_next;

    logic            out_valid_reg, out_valid_next;
    status_t         out_status_reg;
    entry_t          out_removed_reg;
    logic [CW-1:0]   out_count_reg;
    entry_t          out_root_reg;
    logic            out_load;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    entry_t          wr_data;
    logic [AW-1:0]   rd_a_addr;
    logic [AW-1:0]   rd_b_addr;
    entry_t          rd_a_data;
    entry_t          rd_b_data;

    logic [CW-1:0]   count_dec;
    logic [AW-1:0]   parent;
    logic [IW-1:0]   left_idx;
    logic [IW-1:0]   right_idx;
    logic [IW-1:0]   count_ext;
    logic            take_left;
    logic            take_right;
    entry_t          cand;

    bmh_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    assign count_dec = count_reg - 1'b1;
    assign parent    = (pos_reg - 1'b1) >> 1;
    assign left_idx  = {pos_reg, 1'b1};
    assign right_idx = left_idx + 1'b1;
    assign count_ext = IW'(count_reg);

    // sift-down child choice: left first, right only when strictly below the best so far
    assign take_left  = (left_idx < count_ext) &&
                        ($signed(rd_a_data.prio) < $signed(hold_reg.prio));
    assign cand       = take_left ? rd_a_data : hold_reg;
    assign take_right = (right_idx < count_ext) &&
                        ($signed(rd_b_data.prio) < $signed(cand.prio));

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        hold_next    = hold_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = hold_reg;
        rd_a_addr    = left_idx[AW-1:0];
        rd_b_addr    = right_idx[AW-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    status_next  = STATUS_DONE;
                    removed_next = '0;
                    if (s_operation == OP_INSERT) begin
                        if (count_reg == FULL_COUNT) begin
                            status_next = STATUS_FULL;
                            state_next  = ST_DONE;
                        end else begin
                            hold_next  = '{prio: s_priority_req, id: s_patron_id};
                            pos_next   = count_reg[AW-1:0];
                            count_next = count_reg + 1'b1;
                            state_next = ST_UP_RD;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = STATUS_EMPTY;
                            state_next  = ST_DONE;
                        end else begin
                            removed_next = root_reg;
                            count_next   = count_dec;
                            if (count_dec == '0) begin
                                state_next = ST_DONE;
                            end else begin
                                // fetch the last entry, it restarts from the root
                                rd_a_addr  = count_dec[AW-1:0];
                                state_next = ST_LAST_LD;
                            end
                        end
                    end
                end
            end
            ST_UP_RD: begin
                if (pos_reg == '0) begin
                    wr_en      = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    rd_a_addr  = parent;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                wr_en = 1'b1;
                if ($signed(hold_reg.prio) < $signed(rd_a_data.prio)) begin
                    // parent moves down into the hole
                    wr_data    = rd_a_data;
                    pos_next   = parent;
                    state_next = ST_UP_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_LAST_LD: begin
                hold_next  = rd_a_data;
                pos_next   = '0;
                state_next = ST_DN_RD;
            end
            ST_DN_RD: begin
                if (left_idx >= count_ext) begin
                    wr_en      = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DN_CMP;
                end
            end
            ST_DN_CMP: begin
                wr_en = 1'b1;
                if (take_right) begin
                    wr_data    = rd_b_data;
                    pos_next   = right_idx[AW-1:0];
                    state_next = ST_DN_RD;
                end else if (take_left) begin
                    wr_data    = rd_a_data;
                    pos_next   = left_idx[AW-1:0];
                    state_next = ST_DN_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        hold_reg    <= hold_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        // shadow copy of the root entry
        if (wr_en && (wr_addr == '0)) begin
            root_reg <= wr_data;
        end
        if (out_load) begin
            out_status_reg  <= status_reg;
            out_removed_reg <= removed_reg;
            out_count_reg   <= count_reg;
            out_root_reg    <= (count_reg != '0) ? root_reg : '0;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_status           = out_status_reg;
    assign m_removed_priority = out_removed_reg.prio;
    assign m_removed_id       = out_removed_reg.id;
    assign m_entry_count_out  = COUNT_W'(out_count_reg);
    assign m_min_valid        = (out_count_reg != '0);
    assign m_min_priority     = out_root_reg.prio;
    assign m_min_id           = out_root_reg.id;

endmodule

FILE: bench/binary_min_heap_priority_queue_unit_test.sv
module binary_min_heap_priority_queue_unit_test;

    import bmh_pkg::*;

    localparam int CAPACITY    = 32;
    localparam int RANDOM_REQS = 500;
    localparam int HOLD_MARK   = 200;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        status_t                  status;
        logic signed [PRIO_W-1:0] rem_pri;
        logic signed [ID_W-1:0]   rem_id;
        logic [COUNT_W-1:0]       count;
        logic                     min_valid;
        logic signed [PRIO_W-1:0] min_pri;
        logic signed [ID_W-1:0]   min_id;
    } outcome_t;

    typedef struct {
        logic                     op;
        logic signed [PRIO_W-1:0] pri;
        logic signed [ID_W-1:0]   id;
        int                       reps;
        bit                       typed;
        outcome_t                 want;
    } stim_row_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_operation;
    logic signed [PRIO_W-1:0] s_priority_req;
    logic signed [ID_W-1:0]   s_patron_id;
    logic                     m_valid;
    logic                     m_ready;
    logic [1:0]               m_status;
    logic signed [PRIO_W-1:0] m_removed_priority;
    logic signed [ID_W-1:0]   m_removed_id;
    logic [COUNT_W-1:0]       m_entry_count_out;
    logic                     m_min_valid;
    logic signed [PRIO_W-1:0] m_min_priority;
    logic signed [ID_W-1:0]   m_min_id;

    // shadow heap kept in step with every accepted request
    entry_t      heap_mem [CAPACITY];
    int unsigned heap_fill;

    outcome_t  pending_results [$];
    stim_row_t plan [$];

    int  reqs_accepted;
    int  results_seen;
    int  bad_results;
    int  burst_left;
    int  n_insert, n_remove, n_dropped, n_empty, peak_fill;
    bit  hold_done;

    binary_min_heap_priority_queue_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_priority_req     (s_priority_req),
        .s_patron_id        (s_patron_id),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_removed_priority (m_removed_priority),
        .m_removed_id       (m_removed_id),
        .m_entry_count_out  (m_entry_count_out),
        .m_min_valid        (m_min_valid),
        .m_min_priority     (m_min_priority),
        .m_min_id           (m_min_id)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic outcome_t want_of(status_t st, logic signed [PRIO_W-1:0] rp,
                                         logic signed [ID_W-1:0] ri, int cnt, logic mv,
                                         logic signed [PRIO_W-1:0] mp,
                                         logic signed [ID_W-1:0] mi);
        outcome_t w;
        w.status    = st;
        w.rem_pri   = rp;
        w.rem_id    = ri;
        w.count     = cnt[COUNT_W-1:0];
        w.min_valid = mv;
        w.min_pri   = mp;
        w.min_id    = mi;
        return w;
    endfunction

    function automatic stim_row_t plan_row(logic op, logic signed [PRIO_W-1:0] pri,
                                           logic signed [ID_W-1:0] id, int reps,
                                           bit typed, outcome_t want);
        stim_row_t r;
        r.op    = op;
        r.pri   = pri;
        r.id    = id;
        r.reps  = reps;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // insert sifts up past strictly greater parents; remove sifts the last entry
    // down toward the strictly smaller child, left child winning ties
    function automatic outcome_t heap_apply(logic op, logic signed [PRIO_W-1:0] pri,
                                            logic signed [ID_W-1:0] id);
        outcome_t    res;
        int unsigned pos, up, lc, rc, best;
        entry_t      tmp;
        res = want_of(STATUS_DONE, '0, '0, 0, 1'b0, '0, '0);
        if (op == OP_INSERT) begin
            if (heap_fill >= CAPACITY) begin
                res.status = STATUS_FULL;
            end else begin
                heap_mem[heap_fill].prio = pri;
                heap_mem[heap_fill].id   = id;
                pos = heap_fill;
                heap_fill++;
                while (pos != 0) begin
                    up = (pos - 1) / 2;
                    if (!($signed(heap_mem[pos].prio) < $signed(heap_mem[up].prio)))
                        break;
                    tmp           = heap_mem[pos];
                    heap_mem[pos] = heap_mem[up];
                    heap_mem[up]  = tmp;
                    pos = up;
                end
            end
        end else begin
            if (heap_fill == 0) begin
                res.status = STATUS_EMPTY;
            end else begin
                res.rem_pri = heap_mem[0].prio;
                res.rem_id  = heap_mem[0].id;
                heap_fill--;
                if (heap_fill > 0) begin
                    heap_mem[0] = heap_mem[heap_fill];
                    pos = 0;
                    forever begin
                        lc   = 2 * pos + 1;
                        rc   = 2 * pos + 2;
                        best = pos;
                        if (lc < heap_fill &&
                            $signed(heap_mem[lc].prio) < $signed(heap_mem[best].prio))
                            best = lc;
                        if (rc < heap_fill &&
                            $signed(heap_mem[rc].prio) < $signed(heap_mem[best].prio))
                            best = rc;
                        if (best == pos)
                            break;
                        tmp             = heap_mem[pos];
                        heap_mem[pos]   = heap_mem[best];
                        heap_mem[best]  = tmp;
                        pos = best;
                    end
                end
            end
        end
        res.count = heap_fill[COUNT_W-1:0];
        if (heap_fill > 0) begin
            res.min_valid = 1'b1;
            res.min_pri   = heap_mem[0].prio;
            res.min_id    = heap_mem[0].id;
        end
        return res;
    endfunction

    // offer one request, record its expected result once taken, then maybe idle
    task automatic send_req(logic op, logic signed [PRIO_W-1:0] pri,
                            logic signed [ID_W-1:0] id, bit typed, outcome_t typed_want);
        outcome_t predicted;
        int       gap;
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_priority_req <= pri;
        s_patron_id    <= id;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predicted = heap_apply(op, pri, id);
        pending_results.push_back(typed ? typed_want : predicted);
        reqs_accepted++;
        if (op == OP_INSERT)
            n_insert++;
        else
            n_remove++;
        if (predicted.status == STATUS_FULL)
            n_dropped++;
        if (predicted.status == STATUS_EMPTY)
            n_empty++;
        if (heap_fill > peak_fill)
            peak_fill = heap_fill;
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = $urandom_range(0, 7);
            burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(0, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            got.status    = status_t'(m_status);
            got.rem_pri   = m_removed_priority;
            got.rem_id    = m_removed_id;
            got.count     = m_entry_count_out;
            got.min_valid = m_min_valid;
            got.min_pri   = m_min_priority;
            got.min_id    = m_min_id;
            results_seen++;
            if (pending_results.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("result %0d arrived with no request outstanding", results_seen);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    bad_results++;
                    if (bad_results <= 10) begin
                        $display("result %0d expected: st %0d rem %0d/%0d cnt %0d min %0d %0d/%0d",
                                 results_seen, want.status, $signed(want.rem_pri),
                                 $signed(want.rem_id), want.count, want.min_valid,
                                 $signed(want.min_pri), $signed(want.min_id));
                        $display("    got:      st %0d rem %0d/%0d cnt %0d min %0d %0d/%0d",
                                 got.status, $signed(got.rem_pri), $signed(got.rem_id),
                                 got.count, got.min_valid, $signed(got.min_pri),
                                 $signed(got.min_id));
                    end
                end
            end
        end
    end

    // receiver: stall patterns of varying density, plus one long hold-off
    initial begin
        int mode;
        int span;
        int tick;
        m_ready   = 1'b0;
        hold_done = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 60);
            for (tick = 0; tick < span; tick++) begin
                @(negedge aclk);
                if (!hold_done && reqs_accepted >= HOLD_MARK) begin
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge aclk);
                    hold_done = 1'b1;
                end
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    initial begin
        #(8 * 300000);
        $display("binary_min_heap_priority_queue_unit regression: fail");
        $finish;
    end

    initial begin
        stim_row_t r;
        outcome_t  blank;
        logic      op;
        logic signed [PRIO_W-1:0] pri;
        logic signed [ID_W-1:0]   id;
        int        n;
        int        k;
        bit        filling;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_operation    = OP_INSERT;
        s_priority_req = '0;
        s_patron_id    = '0;
        heap_fill      = 0;
        reqs_accepted  = 0;
        results_seen   = 0;
        bad_results    = 0;
        burst_left     = 0;
        n_insert       = 0;
        n_remove       = 0;
        n_dropped      = 0;
        n_empty        = 0;
        peak_fill      = 0;
        blank          = want_of(STATUS_DONE, '0, '0, 0, 1'b0, '0, '0);

        // empty remove, extreme keys and ids, ties, fill to capacity, full inserts
        plan.push_back(plan_row(OP_REMOVE, 0, 0, 1, 1,
                                want_of(STATUS_EMPTY, 0, 0, 0, 1'b0, 0, 0)));
        plan.push_back(plan_row(OP_INSERT, 32'h7fff_ffff, -1, 1, 1,
                                want_of(STATUS_DONE, 0, 0, 1, 1'b1, 32'h7fff_ffff, -1)));
        plan.push_back(plan_row(OP_INSERT, 32'h8000_0000, 32'h7fff_ffff, 1, 1,
                                want_of(STATUS_DONE, 0, 0, 2, 1'b1, 32'h8000_0000,
                                        32'h7fff_ffff)));
        plan.push_back(plan_row(OP_INSERT, 0, 0, 1, 0, blank));
        plan.push_back(plan_row(OP_REMOVE, 0, 0, 1, 1,
                                want_of(STATUS_DONE, 32'h8000_0000, 32'h7fff_ffff, 2, 1'b1,
                                        0, 0)));
        plan.push_back(plan_row(OP_REMOVE, 0, 0, 1, 0, blank));
        plan.push_back(plan_row(OP_REMOVE, 0, 0, 1, 1,
                                want_of(STATUS_DONE, 32'h7fff_ffff, -1, 0, 1'b0, 0, 0)));
        plan.push_back(plan_row(OP_REMOVE, 0, 0, 1, 1,
                                want_of(STATUS_EMPTY, 0, 0, 0, 1'b0, 0, 0)));
        plan.push_back(plan_row(OP_INSERT, 5, 1, 1, 0, blank));
        plan.push_back(plan_row(OP_INSERT, 5, 2, 1, 0, blank));
        plan.push_back(plan_row(OP_INSERT, 5, 3, 1, 0, blank));
        plan.push_back(plan_row(OP_REMOVE, 0, 0, 1, 0, blank));
        plan.push_back(plan_row(OP_INSERT, 5, 4, 1, 0, blank));
        // descending keys, each one climbs to the root
        plan.push_back(plan_row(OP_INSERT, -100, 1000, 29, 0, blank));
        plan.push_back(plan_row(OP_INSERT, 32'h8000_0000, 32'h8000_0000, 1, 1,
                                want_of(STATUS_FULL, 0, 0, 32, 1'b1, -128, 1028)));
        plan.push_back(plan_row(OP_REMOVE, 0, 0, 1, 0, blank));
        plan.push_back(plan_row(OP_INSERT, 32'h7fff_ffff, 0, 1, 0, blank));
        plan.push_back(plan_row(OP_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, 1, 1,
                                want_of(STATUS_FULL, 0, 0, 32, 1'b1, -127, 1027)));
        plan.push_back(plan_row(OP_REMOVE, 0, 0, 4, 0, blank));

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (n = 0; n < plan.size(); n++) begin
            r = plan[n];
            for (k = 0; k < r.reps; k++)
                send_req(r.op, r.pri - k, r.id + k, r.typed, r.want);
        end

        // swing between filling and draining so both full and empty are reached
        filling = 1'b0;
        for (n = 0; n < RANDOM_REQS; n++) begin
            if (heap_fill == CAPACITY && $urandom_range(0, 2) == 0)
                filling = 1'b0;
            else if (heap_fill == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 49) == 0)
                filling = !filling;
            if (filling)
                op = ($urandom_range(0, 99) < 15) ? OP_REMOVE : OP_INSERT;
            else
                op = ($urandom_range(0, 99) < 15) ? OP_INSERT : OP_REMOVE;
            case ($urandom_range(0, 9))
                0: pri = 32'h8000_0000;
                1: pri = 32'h7fff_ffff;
                2, 3, 4: pri = $signed($urandom_range(0, 7)) - 4;
                default: pri = $urandom;
            endcase
            id = $urandom;
            send_req(op, pri, id, 1'b0, blank);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (pending_results.size() != 0)
            bad_results += pending_results.size();

        $display("covered %0d requests (%0d inserts, %0d removes), %0d full, %0d empty",
                 reqs_accepted, n_insert, n_remove, n_dropped, n_empty);
        $display("peak occupancy %0d of %0d, long receiver hold-off %0s, %0d mismatches",
                 peak_fill, CAPACITY, hold_done ? "seen" : "missed", bad_results);
        if (bad_results == 0) begin
            $display("binary_min_heap_priority_queue_unit regression: pass");
        end else begin
            $display("binary_min_heap_priority_queue_unit regression: fail");
        end
        $finish;
    end

endmodule
